// ===== design/sbrs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbrs_pkg: shared types and constants of the signed binary radix sorter
// Word width, pass index width, controller states, command bundle and the
// bit test used by the radix passes.
// ----------------------------------------------------------------------------
package sbrs_pkg;

	localparam int WORD_BITS = 32;
	localparam int POS_BITS  = 6;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_INIT,
		ST_READ,
		ST_DRAIN,
		ST_FETCH,
		ST_PRESENT,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic                take;
		logic                pass_init;
		logic                rd_en;
		logic                rd_sel;
		logic                pass_rd;
		logic                out_load;
		logic                out_last;
		logic                clear;
		logic [POS_BITS-1:0] pass_idx;
	} cmd_t;

	// Bits at or above the word width are copies of the sign bit.
	function automatic logic bit_at(input logic [WORD_BITS-1:0] v,
			input logic [POS_BITS-1:0] pos);
		logic r;
		if (pos[POS_BITS-1]) begin
			r = v[WORD_BITS-1];
		end else begin
			r = v[pos[POS_BITS-2:0]];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== design/sbrs_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbrs_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sbrs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== design/sbrs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbrs_ctrl: sequencer of the radix sorter
// Loads the batch, steps the bit passes over the store and walks the
// sorted result out one word at a time.
// ----------------------------------------------------------------------------
module sbrs_ctrl #(
	parameter int MAX_ITEMS  = 64,
	parameter int VALUE_BITS = 32,
	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1,
	localparam int CW = $clog2(MAX_ITEMS + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          sample_valid,
	input  wire logic          final_item,
	input  wire logic [CW-1:0] item_count,
	input  wire logic          out_fire,
	output logic               sample_ready,
	output sbrs_pkg::cmd_t     cmd,
	output logic      [AW-1:0] rd_addr
);
	import sbrs_pkg::*;

	localparam int PASS_W = $clog2(VALUE_BITS);
	localparam logic EMIT_SEL = (VALUE_BITS % 2) == 1;

	state_t            state_q, state_d;
	logic [AW-1:0]     idx_q, idx_d;
	logic [PASS_W-1:0] pass_q, pass_d;
	logic              last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			idx_q   <= '0;
			pass_q  <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			pass_q  <= pass_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		pass_d       = pass_q;
		cmd          = '0;
		cmd.pass_idx = POS_BITS'(pass_q);
		rd_addr      = idx_q;
		sample_ready = 1'b0;
		last         = (CW'(idx_q) + CW'(1)) == item_count;
		case (state_q)
			ST_LOAD: begin
				sample_ready = 1'b1;
				if (sample_valid) begin
					cmd.take = 1'b1;
					if (final_item) begin
						pass_d  = '0;
						state_d = ST_INIT;
					end
				end
			end
			ST_INIT: begin
				cmd.pass_init = 1'b1;
				idx_d         = '0;
				state_d       = ST_READ;
			end
			ST_READ: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = pass_q[0];
				cmd.pass_rd = 1'b1;
				if (last) begin
					state_d = ST_DRAIN;
				end else begin
					idx_d = idx_q + AW'(1);
				end
			end
			ST_DRAIN: begin
				// last word of the pass is written this cycle
				if (pass_q == PASS_W'(VALUE_BITS - 1)) begin
					idx_d   = '0;
					state_d = ST_FETCH;
				end else begin
					pass_d  = pass_q + PASS_W'(1);
					state_d = ST_INIT;
				end
			end
			ST_FETCH: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = EMIT_SEL;
				state_d    = ST_PRESENT;
			end
			ST_PRESENT: begin
				cmd.out_load = 1'b1;
				cmd.out_last = last;
				state_d      = ST_HOLD;
			end
			ST_HOLD: begin
				if (out_fire) begin
					if (last) begin
						cmd.clear = 1'b1;
						state_d   = ST_LOAD;
					end else begin
						idx_d      = idx_q + AW'(1);
						rd_addr    = idx_q + AW'(1);
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = EMIT_SEL;
						state_d    = ST_PRESENT;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== design/sbrs_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbrs_dpath: storage and partition datapath of the radix sorter
// Two RAMs used in ping-pong, the stable split write pointers, the lead
// count for the next pass and the output register.
// ----------------------------------------------------------------------------
module sbrs_dpath #(
	parameter int MAX_ITEMS  = 64,
	parameter int VALUE_BITS = 32,
	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1,
	localparam int CW = $clog2(MAX_ITEMS + 1)
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire sbrs_pkg::cmd_t                 cmd,
	input  wire logic [AW-1:0]                  rd_addr,
	input  wire logic [sbrs_pkg::WORD_BITS-1:0] sample_value,
	input  wire logic                           result_ready,
	output logic      [CW-1:0]                  item_count,
	output logic                                out_fire,
	output logic                                result_valid,
	output logic      [sbrs_pkg::WORD_BITS-1:0] sorted_value,
	output logic                                end_of_batch,
	output logic                                dropped_flag
);
	import sbrs_pkg::*;

	localparam logic [POS_BITS-1:0] SIGN_POS = POS_BITS'(VALUE_BITS - 1);

	logic [CW-1:0]        count_q, lead_cnt_q, lo_q, hi_q;
	logic                 overflow_q;
	logic                 rdv_s1, sel_s1;
	logic [POS_BITS-1:0]  pos_s1;
	logic                 out_valid_q, eob_q, drop_q;
	logic [WORD_BITS-1:0] out_data_q;

	logic [WORD_BITS-1:0] a_rdata, b_rdata, rd_data, a_wdata;
	logic                 a_we, b_we, store_ok, lead_now, lead_next;
	logic [AW-1:0]        a_waddr, dst_addr;
	logic [POS_BITS-1:0]  pos_next;

	assign store_ok  = count_q != CW'(MAX_ITEMS);
	assign rd_data   = sel_s1 ? b_rdata : a_rdata;
	assign pos_next  = pos_s1 + POS_BITS'(1);
	// sign pass puts ones first, every other pass zeros first
	assign lead_now  = bit_at(rd_data, pos_s1) == (pos_s1 == SIGN_POS);
	assign lead_next = bit_at(rd_data, pos_next) == (pos_next == SIGN_POS);
	assign dst_addr  = lead_now ? lo_q[AW-1:0] : hi_q[AW-1:0];

	assign a_we    = (cmd.take && store_ok) || (rdv_s1 && sel_s1);
	assign a_waddr = cmd.take ? count_q[AW-1:0] : dst_addr;
	assign a_wdata = cmd.take ? sample_value : rd_data;
	assign b_we    = rdv_s1 && !sel_s1;

	sbrs_ram #(.WIDTH(WORD_BITS), .DEPTH(MAX_ITEMS)) u_store (
		.clk   (clk),
		.we    (a_we),
		.waddr (a_waddr),
		.wdata (a_wdata),
		.re    (cmd.rd_en && !cmd.rd_sel),
		.raddr (rd_addr),
		.rdata (a_rdata)
	);

	sbrs_ram #(.WIDTH(WORD_BITS), .DEPTH(MAX_ITEMS)) u_part (
		.clk   (clk),
		.we    (b_we),
		.waddr (dst_addr),
		.wdata (rd_data),
		.re    (cmd.rd_en && cmd.rd_sel),
		.raddr (rd_addr),
		.rdata (b_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			overflow_q  <= 1'b0;
			lead_cnt_q  <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			rdv_s1      <= 1'b0;
			sel_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rdv_s1 <= cmd.rd_en && cmd.pass_rd;
			if (cmd.rd_en) begin
				sel_s1 <= cmd.rd_sel;
			end
			if (cmd.take) begin
				if (store_ok) begin
					count_q    <= count_q + CW'(1);
					lead_cnt_q <= lead_cnt_q + CW'(bit_at(sample_value, '0) ==
						(SIGN_POS == '0));
				end else begin
					overflow_q <= 1'b1;
				end
			end
			if (cmd.pass_init) begin
				lo_q       <= '0;
				hi_q       <= lead_cnt_q;
				lead_cnt_q <= '0;
			end
			if (rdv_s1) begin
				if (lead_now) begin
					lo_q <= lo_q + CW'(1);
				end else begin
					hi_q <= hi_q + CW'(1);
				end
				lead_cnt_q <= lead_cnt_q + CW'(lead_next);
			end
			if (cmd.clear) begin
				count_q    <= '0;
				overflow_q <= 1'b0;
				lead_cnt_q <= '0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdv_s1) begin
			pos_s1 <= pos_s1;
		end else begin
			pos_s1 <= cmd.pass_idx;
		end
		if (cmd.out_load) begin
			out_data_q <= rd_data;
			eob_q      <= cmd.out_last;
			drop_q     <= overflow_q;
		end
	end

	assign item_count   = count_q;
	assign out_fire     = out_valid_q && result_ready;
	assign result_valid = out_valid_q;
	assign sorted_value = out_data_q;
	assign end_of_batch = eob_q;
	assign dropped_flag = drop_q;

endmodule
`default_nettype wire

// ===== design/signed_binary_radix_sort.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// signed_binary_radix_sort: batch sorter for signed words
// Collects a batch of signed words, sorts them ascending with a stable
// bit-at-a-time radix sort and streams the ordered batch back out.
// ----------------------------------------------------------------------------
// Usage: present one signed word per sample handshake and raise final_item on
// the last word of a batch. Each word taken is written into the store RAM. Once
// the last word is in, the block stops taking samples and runs VALUE_BITS bit
// passes over the batch, lowest bit first; each pass streams the N stored words
// through one RAM read port and writes them into the other RAM, zeros first
// (ones first on the sign bit). The ordered words then leave through the
// registered RAM read and the output register, the next word being fetched only
// after the current one is taken; end_of_batch marks the last one and
// dropped_flag is high on every word of a batch that offered more than
// MAX_ITEMS words (the surplus is discarded). A new batch is taken the cycle
// after the last result word leaves. Bits above bit 31 count as copies of the
// sign; with VALUE_BITS below 32 only the low VALUE_BITS bits order the words,
// bit VALUE_BITS-1 as sign.
// ----------------------------------------------------------------------------
module signed_binary_radix_sort #(
	parameter int MAX_ITEMS  = 64,
	parameter int VALUE_BITS = 32
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           sample_valid,
	output logic                                sample_ready,
	input  wire logic [sbrs_pkg::WORD_BITS-1:0] sample_value,
	input  wire logic                           final_item,
	output logic                                result_valid,
	input  wire logic                           result_ready,
	output logic      [sbrs_pkg::WORD_BITS-1:0] sorted_value,
	output logic                                end_of_batch,
	output logic                                dropped_flag
);
	import sbrs_pkg::*;

	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW = $clog2(MAX_ITEMS + 1);

	cmd_t          cmd;
	logic [AW-1:0] rd_addr;
	logic [CW-1:0] item_count;
	logic          out_fire;

	// Sequencer: load, bit passes, output walk.
	sbrs_ctrl #(
		.MAX_ITEMS  (MAX_ITEMS),
		.VALUE_BITS (VALUE_BITS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.final_item   (final_item),
		.item_count   (item_count),
		.out_fire     (out_fire),
		.sample_ready (sample_ready),
		.cmd          (cmd),
		.rd_addr      (rd_addr)
	);

	// Storage, split pointers and output register.
	sbrs_dpath #(
		.MAX_ITEMS  (MAX_ITEMS),
		.VALUE_BITS (VALUE_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.rd_addr      (rd_addr),
		.sample_value (sample_value),
		.result_ready (result_ready),
		.item_count   (item_count),
		.out_fire     (out_fire),
		.result_valid (result_valid),
		.sorted_value (sorted_value),
		.end_of_batch (end_of_batch),
		.dropped_flag (dropped_flag)
	);

endmodule
`default_nettype wire

// ===== design/sbrs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbrs_checker: port-level checks of the radix sorter
// Watches the two channels and the batch sequencing seen from outside.
// ----------------------------------------------------------------------------
module sbrs_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           sample_valid,
	input wire logic                           sample_ready,
	input wire logic [sbrs_pkg::WORD_BITS-1:0] sample_value,
	input wire logic                           final_item,
	input wire logic                           result_valid,
	input wire logic                           result_ready,
	input wire logic [sbrs_pkg::WORD_BITS-1:0] sorted_value,
	input wire logic                           end_of_batch,
	input wire logic                           dropped_flag
);

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(sorted_value)
		&& $stable(end_of_batch) && $stable(dropped_flag))
		else $error("result word changed while stalled");

	// never take samples while results are on offer
	a_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(sample_ready && result_valid))
		else $error("sample ready while result pending");

	// close the batch: stop taking samples after the last one
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready && final_item |=> !sample_ready)
		else $error("sample taken after final item");

	// reopen for the next batch right after the last result
	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && end_of_batch |=> sample_ready)
		else $error("not ready for next batch");

endmodule

bind signed_binary_radix_sort sbrs_checker u_sbrs_checker (.*);
`default_nettype wire
